/* rtl/core/tdp_pkg.sv */
// tdp_pkg: shared widths and types for the trial division prime tester
// no dependencies; used by tdp_rem_unit, trial_division_prime_test and the testbench
package tdp_pkg;

    // width of the tested number
    localparam int WIDTH = 32;
    // trial divisor width: covers the first divisor whose square passes the number
    localparam int DIV_W = (WIDTH + 1) / 2 + 1;
    // width of the running divisor square
    localparam int SQ_W  = WIDTH + 2;
    // bit counter of the serial remainder unit
    localparam int CNT_W = (WIDTH > 2) ? $clog2(WIDTH) : 1;

    // status from the remainder unit to the sequencer
    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_status;

endpackage

/* rtl/core/tdp_rem_unit.sv */
// tdp_rem_unit: bit-serial restoring remainder, one dividend bit per cycle
// depends on tdp_pkg
module tdp_rem_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tdp_pkg::WIDTH-1:0] i_dividend,
    input  logic [tdp_pkg::DIV_W-1:0] i_divisor,
    output tdp_pkg::t_rem_status      o_status
);

    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic                      r_zero, n_zero;
    logic [tdp_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [tdp_pkg::WIDTH-1:0] r_dvd, n_dvd;
    logic [tdp_pkg::DIV_W-1:0] r_dsr, n_dsr;
    logic [tdp_pkg::DIV_W-1:0] r_rem, n_rem;
    logic [tdp_pkg::DIV_W:0]   shifted;
    logic [tdp_pkg::DIV_W:0]   diff;
    logic [tdp_pkg::DIV_W-1:0] rem_step;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        shifted  = {r_rem, r_dvd[tdp_pkg::WIDTH-1]};
        diff     = shifted - {1'b0, r_dsr};
        if (shifted >= {1'b0, r_dsr}) begin
            rem_step = diff[tdp_pkg::DIV_W-1:0];
        end else begin
            rem_step = shifted[tdp_pkg::DIV_W-1:0];
        end
    end

    // step sequencing
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_zero = r_zero;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = tdp_pkg::CNT_W'(tdp_pkg::WIDTH - 1);
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = rem_step;
            n_dvd = {r_dvd[tdp_pkg::WIDTH-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_zero = (rem_step == '0);
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_zero <= n_zero;
        r_cnt  <= n_cnt;
        r_dvd  <= n_dvd;
        r_dsr  <= n_dsr;
        r_rem  <= n_rem;
    end

    assign o_status.done = r_done;
    assign o_status.zero = r_zero;

    // the unit only reports done at the end of a running pass
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("remainder done without a running pass");

    // the partial remainder stays below the divisor while running
    a_rem_below_dsr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !$past(i_start)) |-> (r_rem < r_dsr))
        else $error("partial remainder not below divisor");

    // a pass started while one is running would corrupt it
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("remainder unit restarted while busy");

endmodule

/* rtl/core/trial_division_prime_test.sv */
// Trial division prime tester: 0 and 1 get a registered result without trial division; otherwise
// each trial divisor d = 2, 3, 5, 7, 9, ... with d*d <= number takes one pass of the shared serial
// remainder unit (one remainder bit per cycle), and the number is prime once the next square passes it.
// One number at a time: busy stays high until the result strobe is issued (it stays low for 0 and 1).
// Result o_is_prime is valid for one cycle with o_valid; the receiver cannot stall.
// Synchronous active-low reset returns the sequencer to idle with no result pending.
module trial_division_prime_test (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [tdp_pkg::WIDTH-1:0] i_number,
    output logic                      busy,
    output logic                      o_valid,
    output logic                      o_is_prime
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]                r_state, n_state;
    logic                      r_valid, n_valid;
    logic                      r_prime, n_prime;
    logic [tdp_pkg::WIDTH-1:0] r_num, n_num;
    logic [tdp_pkg::DIV_W-1:0] r_div, n_div;
    logic [tdp_pkg::SQ_W-1:0]  r_sq, n_sq;
    logic                      rem_start;
    tdp_pkg::t_rem_status      rem_status;
    logic                      sq_past_num;

    assign sq_past_num = (r_sq > {2'b00, r_num});

    // shared remainder unit: r_num mod r_div
    tdp_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_num),
        .i_divisor  (r_div),
        .o_status   (rem_status)
    );

    // sequencer over trial divisors
    always_comb begin
        n_state   = r_state;
        n_valid   = 1'b0;
        n_prime   = r_prime;
        n_num     = r_num;
        n_div     = r_div;
        n_sq      = r_sq;
        rem_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_num = i_number;
                    n_div = tdp_pkg::DIV_W'(2);
                    n_sq  = tdp_pkg::SQ_W'(4);
                    if (i_number < tdp_pkg::WIDTH'(2)) begin
                        n_valid = 1'b1;
                        n_prime = 1'b0;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (sq_past_num) begin
                    n_valid = 1'b1;
                    n_prime = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    rem_start = 1'b1;
                    n_state   = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (rem_status.done) begin
                    if (rem_status.zero) begin
                        n_valid = 1'b1;
                        n_prime = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        // after 2 only odd divisors: (d+2)^2 = d^2 + 4d + 4
                        if (r_div == tdp_pkg::DIV_W'(2)) begin
                            n_div = tdp_pkg::DIV_W'(3);
                            n_sq  = tdp_pkg::SQ_W'(9);
                        end else begin
                            n_div = r_div + tdp_pkg::DIV_W'(2);
                            n_sq  = r_sq + tdp_pkg::SQ_W'({r_div, 2'b00})
                                         + tdp_pkg::SQ_W'(4);
                        end
                        n_state = ST_CHECK;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prime <= n_prime;
        r_num   <= n_num;
        r_div   <= n_div;
        r_sq    <= n_sq;
    end

    assign busy       = (r_state != ST_IDLE);
    assign o_valid    = r_valid;
    assign o_is_prime = r_prime;

    // a result only follows an accepted number or a running test
    a_valid_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy || start))
        else $error("result transfer without a number");

    // a prime result never comes for 0 or 1
    a_prime_ge_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_prime) |-> (r_num >= tdp_pkg::WIDTH'(2)))
        else $error("0 or 1 reported prime");

    // a divisor is only tried while its square does not pass the number
    a_div_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT) |-> !sq_past_num)
        else $error("trial divisor beyond the square root");

    // remainder results arrive only while the sequencer waits for them
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_status.done |-> (r_state == ST_WAIT))
        else $error("remainder done outside wait state");

endmodule

/* sim/tb_trial_division_prime_test.sv */
// tb_trial_division_prime_test: self-checking bench for the trial division prime tester
// drives numbers over the start/busy handshake and checks each o_is_prime strobe in order
// depends on tdp_pkg and trial_division_prime_test
module tb_trial_division_prime_test;

    localparam int          CLK_HALF       = 4;
    localparam int          RESET_CYCLES   = 8;
    localparam int          RANDOM_ITEMS   = 96;
    localparam int          MAX_CYCLES     = 4_000_000;
    localparam int          DRAIN_CYCLES   = 64;
    localparam int          MAX_REPORTS    = 10;
    // keeps wide random numbers cheap: at most this many trial divisors
    localparam int unsigned WIDE_TRY_LIMIT = 256;

    typedef logic [tdp_pkg::WIDTH-1:0] t_number;

    // one expected verdict per accepted number
    typedef struct {
        t_number number;
        bit      is_prime;
    } t_verdict;

    // directed row: verdict typed in only when known is set
    typedef struct packed {
        t_number number;
        logic    known;
        logic    is_prime;
    } t_directed_row;

    localparam int N_DIRECTED = 18;
    localparam t_directed_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{32'd0,          1'b1, 1'b0},
        '{32'd1,          1'b1, 1'b0},
        '{32'd2,          1'b1, 1'b1},
        '{32'd3,          1'b1, 1'b1},
        '{32'd4,          1'b0, 1'b0},
        '{32'd5,          1'b0, 1'b0},
        '{32'd9,          1'b0, 1'b0},
        '{32'd25,         1'b0, 1'b0},
        '{32'd49,         1'b0, 1'b0},
        '{32'd121,        1'b0, 1'b0},
        '{32'd65537,      1'b0, 1'b0},
        '{32'd1048573,    1'b0, 1'b0},
        '{32'd16777213,   1'b0, 1'b0},
        '{32'h5555_5555,  1'b0, 1'b0},
        '{32'hAAAA_AAAA,  1'b1, 1'b0},
        '{32'h8000_0000,  1'b1, 1'b0},
        '{32'hFFFF_FFFE,  1'b1, 1'b0},
        '{32'hFFFF_FFFF,  1'b0, 1'b0}
    };

    logic    i_clk    = 1'b0;
    logic    i_rst_n  = 1'b0;
    logic    start    = 1'b0;
    t_number i_number = '0;
    logic    busy;
    logic    o_valid;
    logic    o_is_prime;

    t_verdict    pending_verdicts [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int          burst_left     = 0;

    always #CLK_HALF i_clk = ~i_clk;

    trial_division_prime_test DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_number   (i_number),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_is_prime (o_is_prime)
    );

    // trial division up to the square root, also counting the divisors tried
    function automatic bit primality_of(input t_number value, output int unsigned divisions);
        longint unsigned n;
        longint unsigned d;
        n = value;
        divisions = 0;
        if (n < 2) return 1'b0;
        for (d = 2; d <= n / d; d++) begin
            divisions++;
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // mostly small numbers, wide ones only with an early divisor, a few mid-size primes
    function automatic t_number pick_number();
        t_number     value;
        int unsigned divisions;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            value = t_number'($urandom_range(0, 15));
        end else if (roll < 55) begin
            value = t_number'($urandom_range(16, 65535));
        end else if (roll < 90) begin
            do begin
                value = t_number'($urandom);
                void'(primality_of(value, divisions));
            end while (divisions > WIDE_TRY_LIMIT);
        end else begin
            do begin
                value = t_number'($urandom_range(1 << 16, (1 << 20) - 1));
            end while (!primality_of(value, divisions));
        end
        return value;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", what);
    endtask

    // bursts of back-to-back transfers with random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // present one number and hold it until the transfer happens
    task automatic transfer_number(input t_number value, input bit known, input bit known_prime);
        int unsigned divisions;
        t_verdict    verdict;
        pace_sender();
        start    <= 1'b1;
        i_number <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        verdict.number   = value;
        verdict.is_prime = known ? known_prime : primality_of(value, divisions);
        pending_verdicts.push_back(verdict);
    endtask

    // sender holds off until every verdict has come back
    task automatic pause_until_drained();
        start <= 1'b0;
        wait (pending_verdicts.size() == 0);
        @(posedge i_clk);
        burst_left = 0;
    endtask

    // result check against the oldest pending verdict
    always @(posedge i_clk) begin
        t_verdict oldest;
        if (i_rst_n && o_valid) begin
            if (pending_verdicts.size() == 0) begin
                flag_mismatch($sformatf("unexpected result is_prime=%b", o_is_prime));
            end else begin
                oldest = pending_verdicts.pop_front();
                if (o_is_prime !== oldest.is_prime)
                    flag_mismatch($sformatf("number %0d: expected is_prime=%b, got %b",
                                            oldest.number, oldest.is_prime, o_is_prime));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus: reset, directed table, then random numbers
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++)
            transfer_number(DIRECTED_ROWS[k].number, DIRECTED_ROWS[k].known,
                            DIRECTED_ROWS[k].is_prime);
        pause_until_drained();

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            transfer_number(pick_number(), 1'b0, 1'b0);
            if (k == RANDOM_ITEMS / 2) pause_until_drained();
        end
        start <= 1'b0;

        // drain, then watch for stray strobes
        wait (pending_verdicts.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* trial_division_prime_test.f */
rtl/core/tdp_pkg.sv
rtl/core/tdp_rem_unit.sv
rtl/core/trial_division_prime_test.sv
sim/tb_trial_division_prime_test.sv
